>>> hw/rtl/c3br_pkg.sv
// ============================================================================
// c3br_pkg
// Shared widths, register indexes and transaction types of the 3x3
// convolution unit.
// ============================================================================
`default_nettype none

package c3br_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 3 * COEF_W;
  localparam int BIAS_W  = 8;
  localparam int CONV_W  = 16;
  localparam int RELU_W  = 15;
  localparam int POS_W   = 4;

  // Datapath widths: product, row sum of three, total of nine, final value
  localparam int PROD_W  = COEF_W + PIX_W;
  localparam int RSUM_W  = PROD_W + 2;
  localparam int SUM_W   = PROD_W + 4;
  localparam int VAL_W   = SUM_W + 2;

  // Default geometry and coefficient format
  localparam int DEF_IMAGE_WIDTH    = 16;
  localparam int DEF_IMAGE_HEIGHT   = 16;
  localparam int DEF_COEF_FRAC_BITS = 12;
  localparam int QUEUE_DEPTH        = 4;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_KERNEL_TOP    = 2'd0;
  localparam logic [1:0] REG_KERNEL_MIDDLE = 2'd1;
  localparam logic [1:0] REG_KERNEL_BOTTOM = 2'd2;
  localparam logic [1:0] REG_BIAS          = 2'd3;

  localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd1;

  // Input transaction
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic                    frame_start;
  } c3br_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic [RELU_W-1:0]        relu_value;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic                     frame_last;
  } c3br_out_t;

  // One full window queued for the arithmetic back end
  // pix index is row*3 + column, row 0 top, column 0 left (oldest)
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic                  last;
  } c3br_job_t;

  // Kernel and bias settings
  typedef struct packed {
    logic [KROW_W-1:0]        k_top;
    logic [KROW_W-1:0]        k_mid;
    logic [KROW_W-1:0]        k_bot;
    logic signed [BIAS_W-1:0] bias;
  } c3br_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/c3br_front.sv
// ============================================================================
// c3br_front
// Accepts pixels, tracks raster position, keeps the two line stores and the
// 3x3 window, and queues every full window.
// ============================================================================
`default_nettype none

module c3br_front import c3br_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire c3br_in_t  in_data,
  output logic           in_stall,
  input  wire logic      q_full,
  output logic           q_push,
  output c3br_job_t      q_job
);

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);

  // Position counters
  logic [CW-1:0] col_cnt_r, col_cnt_nxt, cur_col;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt, cur_row;
  logic          in_acc;

  // Stage holding the pixel while its line-store read completes
  logic                    s1_valid_r;
  logic [PIX_W-1:0]        s1_px_r;
  logic [CW-1:0]           s1_col_r;
  logic                    s1_emit_r;
  logic [POS_W-1:0]        s1_row4_r, s1_col4_r;
  logic                    s1_last_r;
  logic                    s1_adv;

  // Line stores with registered read and write-to-read bypass
  logic [PIX_W-1:0] upper_mem [IMAGE_WIDTH];
  logic [PIX_W-1:0] lower_mem [IMAGE_WIDTH];
  logic [PIX_W-1:0] rd_upper_r, rd_lower_r;
  logic [PIX_W-1:0] byp_upper_r, byp_lower_r;
  logic             byp_r;
  logic [PIX_W-1:0] s1_upper, s1_lower;

  // Window, [row][column], column 2 newest
  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !q_full);
  assign in_stall = s1_valid_r && !s1_adv;

  // Position of the incoming pixel and of the next one
  always_comb begin
    cur_col     = in_data.frame_start ? '0 : col_cnt_r;
    cur_row     = in_data.frame_start ? '0 : row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (cur_col == CW'(IMAGE_WIDTH - 1)) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (cur_row == RW'(IMAGE_HEIGHT - 1)) ? '0 : cur_row + RW'(1);
      end else begin
        col_cnt_nxt = cur_col + CW'(1);
        row_cnt_nxt = cur_row;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the holding stage, classified on entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_data.pixel;
      s1_col_r  <= cur_col;
      s1_emit_r <= (cur_row >= RW'(2)) && (cur_col >= CW'(2));
      s1_row4_r <= POS_W'(cur_row) - POS_W'(2);
      s1_col4_r <= POS_W'(cur_col) - POS_W'(2);
      s1_last_r <= (cur_row == RW'(IMAGE_HEIGHT - 1)) && (cur_col == CW'(IMAGE_WIDTH - 1));
    end
  end

  // Effective line-store data: bypass covers a write to the same column
  // landing at the edge the read was issued
  assign s1_upper = byp_r ? byp_upper_r : rd_upper_r;
  assign s1_lower = byp_r ? byp_lower_r : rd_lower_r;

  // Line store write: the column shifts up one row
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      upper_mem[s1_col_r] <= s1_lower;
      lower_mem[s1_col_r] <= s1_px_r;
    end
  end

  // Line store read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_upper_r  <= upper_mem[cur_col];
      rd_lower_r  <= lower_mem[cur_col];
      byp_r       <= s1_adv && (s1_col_r == cur_col);
      byp_upper_r <= s1_lower;
      byp_lower_r <= s1_px_r;
    end
  end

  // Window shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = s1_upper;
    win_nxt[1][2] = s1_lower;
    win_nxt[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // Queue a full window
  always_comb begin
    q_push = s1_adv && s1_emit_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q_job.pix[r*3 + c] = win_nxt[r][c];
      end
    end
    q_job.row  = s1_row4_r;
    q_job.col  = s1_col4_r;
    q_job.last = s1_last_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/c3br_queue.sv
// ============================================================================
// c3br_queue
// Short show-ahead queue of window jobs between front and back end.
// ============================================================================
`default_nettype none

module c3br_queue import c3br_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire c3br_job_t  push_job,
  output logic            full,
  input  wire logic       pop,
  output c3br_job_t       pop_job,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  c3br_job_t     store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = store_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + NW'(1);
        2'b01:   count_r <= count_r - NW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  // Checks on the front and back end use of the queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("window queue overrun");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("window queue underrun");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + NW'(1))
    else $error("window queue count out of step");

endmodule

`default_nettype wire

>>> hw/rtl/c3br_back.sv
// ============================================================================
// c3br_back
// Arithmetic back end: nine products, adder tree, rounding half away from
// zero, bias, saturation and ReLU, into the result register.
// ============================================================================
`default_nettype none

module c3br_back import c3br_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire c3br_cfg_t  cfg,
  input  wire logic       q_empty,
  input  wire c3br_job_t  q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output c3br_out_t       out_data
);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

  localparam logic [SUM_W:0] HALF = (SUM_W + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] SAT_MIN = -VAL_W'(32768);

  logic en;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  meta_t m1_r, m2_r, m3_r, m4_r;

  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [PROD_W-1:0] prod_r   [9];
  logic signed [RSUM_W-1:0] rsum_r   [3];
  logic signed [SUM_W-1:0]  tot_r;
  logic                     neg_r;
  logic [SUM_W-1:0]         rnd_r;

  logic [SUM_W-1:0]         mag;
  logic [SUM_W:0]           mag_half;
  logic signed [VAL_W-1:0]  sval, val;
  logic signed [CONV_W-1:0] conv;
  c3br_out_t                out_r;

  // The pipeline moves whenever the result register is free or being taken
  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Products of coefficient and pixel
  always_comb begin
    logic [KROW_W-1:0]        krow;
    logic signed [COEF_W-1:0] c;
    logic signed [PIX_W-1:0]  p;
    for (int i = 0; i < 9; i++) begin
      krow = (i < 3) ? cfg.k_top : ((i < 6) ? cfg.k_mid : cfg.k_bot);
      c = krow[(i % 3) * COEF_W +: COEF_W];
      p = q_job.pix[i];
      prod_nxt[i] = c * p;
    end
  end

  // Rounding of the magnitude
  always_comb begin
    mag      = tot_r[SUM_W-1] ? SUM_W'(-tot_r) : SUM_W'(tot_r);
    mag_half = {1'b0, mag} + HALF;
  end

  // Sign, bias and saturation
  always_comb begin
    sval = $signed({2'b00, rnd_r});
    if (neg_r) begin
      sval = -sval;
    end
    val = sval + VAL_W'(cfg.bias);
    if (val > SAT_MAX) begin
      conv = 16'sh7FFF;
    end else if (val < SAT_MIN) begin
      conv = -16'sh8000;
    end else begin
      conv = CONV_W'(val);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= !q_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      m1_r <= '{row: q_job.row, col: q_job.col, last: q_job.last};

      for (int r = 0; r < 3; r++) begin
        rsum_r[r] <= RSUM_W'(prod_r[r*3]) + RSUM_W'(prod_r[r*3 + 1])
                   + RSUM_W'(prod_r[r*3 + 2]);
      end
      m2_r <= m1_r;

      tot_r <= SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
      m3_r  <= m2_r;

      neg_r <= tot_r[SUM_W-1];
      rnd_r <= SUM_W'(mag_half >> COEF_FRAC_BITS);
      m4_r  <= m3_r;

      out_r.conv_value <= conv;
      out_r.relu_value <= (conv > 0) ? conv[RELU_W-1:0] : '0;
      out_r.out_row    <= m4_r.row;
      out_r.out_col    <= m4_r.col;
      out_r.frame_last <= m4_r.last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/conv3x3_bias_relu_unit.sv
// ============================================================================
// conv3x3_bias_relu_unit
// Streaming valid-mode 3x3 convolution with Q4.12 kernel, bias, saturation
// and ReLU.
// ============================================================================
// Usage:
//   Pixels enter on the in_ channel in raster order, one transaction per
//   pixel; frame_start marks the top-left pixel and restarts the position.
//   Each pixel whose 3x3 neighbourhood is complete gives one transaction on
//   the out_ channel with the value, its ReLU and the output row and column;
//   frame_last flags the last result of the map. Other pixels give none.
//   Throughput is one pixel per cycle while in_stall is low; the line stores
//   are simple dual-port memories read at pixel acceptance, ahead of their
//   write from the holding stage, and the nine products run in a five-stage
//   pipeline behind a four-entry window queue. A stall on out_ freezes the
//   arithmetic pipeline; the queue absorbs further windows and in_stall rises
//   only when it is full. Kernel rows (64-bit data, byte addresses 0, 8, 16)
//   and bias (24) are written over the APB-style port; the user must write
//   them only while the block is idle, which the block does not enforce.
//   Reset clears the position counters, the queue and the pipeline, sets the
//   kernel to zero and the bias to one. No clearing pass is needed.
// ============================================================================
`default_nettype none

module conv3x3_bias_relu_unit import c3br_pkg::*; #(
  parameter int IMAGE_WIDTH    = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT   = DEF_IMAGE_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Pixel channel
  input  wire logic              in_valid,
  input  wire c3br_in_t          in_data,
  output logic                   in_stall,
  // Result channel
  output logic                   out_valid,
  output c3br_out_t              out_data,
  input  wire logic              out_stall,
  // Configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [KROW_W-1:0] k_top_r, k_mid_r, k_bot_r;
  logic [BIAS_W-1:0] bias_r;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  c3br_cfg_t         cfg;

  logic      q_push, q_full, q_pop, q_empty;
  c3br_job_t push_job, pop_job;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_AW-1:3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r <= '0;
      k_mid_r <= '0;
      k_bot_r <= '0;
      bias_r  <= BIAS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KERNEL_TOP:    k_top_r <= cfg_pwdata[KROW_W-1:0];
        REG_KERNEL_MIDDLE: k_mid_r <= cfg_pwdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: k_bot_r <= cfg_pwdata[KROW_W-1:0];
        REG_BIAS:          bias_r  <= cfg_pwdata[BIAS_W-1:0];
        default:           bias_r  <= bias_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_KERNEL_TOP:    cfg_prdata = CFG_DW'(k_top_r);
      REG_KERNEL_MIDDLE: cfg_prdata = CFG_DW'(k_mid_r);
      REG_KERNEL_BOTTOM: cfg_prdata = CFG_DW'(k_bot_r);
      REG_BIAS:          cfg_prdata = CFG_DW'(bias_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg.k_top = k_top_r;
  assign cfg.k_mid = k_mid_r;
  assign cfg.k_bot = k_bot_r;
  assign cfg.bias  = $signed(bias_r);

  c3br_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  c3br_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  c3br_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> test/conv3x3_bias_relu_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// conv3x3_bias_relu_unit_tb
// Self-checking bench for the streaming 3x3 convolution unit. Pixel bursts
// from a directed table, then random frames, go through the in_ channel
// under three idling mixes. Every result transaction is checked against a
// behavioural model of the line stores, window, Q4.12 sum, rounding, bias,
// saturation and ReLU.
// ============================================================================

module conv3x3_bias_relu_unit_tb;
  import c3br_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 12;
  localparam int PIX_PER_SET   = 125;
  localparam int IMG_W         = DEF_IMAGE_WIDTH;
  localparam int IMG_H         = DEF_IMAGE_HEIGHT;
  localparam longint ROUND_HALF = longint'(1) << (DEF_COEF_FRAC_BITS - 1);

  // One directed burst: optional kernel/bias setting, then a pixel ramp that
  // opens with frame_start. The same row goes to all three kernel registers.
  typedef struct packed {
    bit                       set_cfg;
    logic [KROW_W-1:0]        krow;
    logic signed [BIAS_W-1:0] bias;
    logic signed [PIX_W-1:0]  pix0;
    logic signed [PIX_W-1:0]  pix_step;
    int                       count;
    bit                       typed;
    logic signed [CONV_W-1:0] conv_typed;
    logic [RELU_W-1:0]        relu_typed;
  } burst_t;

  localparam int NUM_BURSTS = 11;
  localparam burst_t BURSTS [NUM_BURSTS] = '{
    // reset kernel is zero, bias one; runs over the frame end
    '{1'b0, 48'h0,              8'sd0,    -8'sd128, 8'sd0,  260, 1'b1, 16'sd1,     15'd1},
    // most negative coefficients and pixels, largest bias
    '{1'b1, 48'h8000_8000_8000, 8'sd127,  -8'sd128, 8'sd0,  48,  1'b1, 16'sd9343,  15'd9343},
    '{1'b1, 48'h8000_8000_8000, -8'sd128, 8'sd127,  8'sd0,  48,  1'b1, -16'sd9272, 15'd0},
    '{1'b1, 48'h7FFF_7FFF_7FFF, 8'sd0,    8'sd127,  8'sd0,  48,  1'b1, 16'sd9144,  15'd9144},
    '{1'b1, 48'h7FFF_7FFF_7FFF, 8'sd0,    -8'sd128, 8'sd0,  48,  1'b1, -16'sd9216, 15'd0},
    // sums of exactly n + 0.5: rounding goes away from zero
    '{1'b1, 48'h0800_0800_0800, 8'sd0,    8'sd1,    8'sd0,  48,  1'b1, 16'sd5,     15'd5},
    '{1'b0, 48'h0,              8'sd0,    -8'sd1,   8'sd0,  48,  1'b1, -16'sd5,    15'd0},
    '{1'b1, 48'h0800_0800_0800, -8'sd5,   8'sd1,    8'sd0,  48,  1'b1, 16'sd0,     15'd0},
    // asymmetric kernel, partial frame, then frame start mid-frame
    '{1'b1, 48'h0000_1000_F000, 8'sd0,    -8'sd128, 8'sd7,  100, 1'b0, 16'sd0,     15'd0},
    '{1'b0, 48'h0,              8'sd0,    8'sd5,    8'sd3,  300, 1'b0, 16'sd0,     15'd0},
    '{1'b1, 48'h7FFF_8000_0001, 8'sd127,  8'sd127,  -8'sd1, 60,  1'b0, 16'sd0,     15'd0}
  };

  // DUT connections
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  c3br_in_t               in_data     = '0;
  logic                   in_stall;
  logic                   out_valid;
  c3br_out_t              out_data;
  logic                   out_stall   = 1'b0;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Model state
  logic signed [PIX_W-1:0]  upper_row [IMG_W];
  logic signed [PIX_W-1:0]  lower_row [IMG_W];
  logic signed [PIX_W-1:0]  win [3][3];
  logic [POS_W-1:0]         col_pos;
  logic [POS_W-1:0]         row_pos;
  logic [KROW_W-1:0]        kern [3];
  logic signed [BIAS_W-1:0] bias_r;

  c3br_out_t conv_results_q [$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int settings_applied = 0;

  always #2 clk = ~clk;

  conv3x3_bias_relu_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Model: state after reset
  function automatic void reset_conv_model();
    for (int i = 0; i < IMG_W; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) win[r][c] = '0;
      kern[r] = '0;
    end
    col_pos = '0;
    row_pos = '0;
    bias_r  = BIAS_RESET;
  endfunction

  // Model: one pixel in, zero or one convolution result out
  function automatic void convolve_pixel(input c3br_in_t item, output bit produced,
                                         output c3br_out_t res);
    longint acc;
    longint mag;
    longint rnd;
    longint val;
    if (item.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_row[col_pos];
    win[1][2] = lower_row[col_pos];
    win[2][2] = item.pixel;
    upper_row[col_pos] = lower_row[col_pos];
    lower_row[col_pos] = item.pixel;

    res = '0;
    produced = (row_pos >= 2) && (col_pos >= 2);
    if (produced) begin
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc += longint'($signed(kern[r][c*COEF_W +: COEF_W])) * longint'(win[r][c]);
      // round half away from zero, then bias and clamp
      mag = (acc < 0) ? -acc : acc;
      rnd = (mag + ROUND_HALF) >>> DEF_COEF_FRAC_BITS;
      val = (acc < 0) ? -rnd : rnd;
      val += longint'(bias_r);
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      res.conv_value = val[CONV_W-1:0];
      res.relu_value = (val > 0) ? val[RELU_W-1:0] : '0;
      res.out_row    = row_pos - 4'd2;
      res.out_col    = col_pos - 4'd2;
      res.frame_last = (row_pos == IMG_H - 1) && (col_pos == IMG_W - 1);
    end

    if (col_pos == IMG_W - 1) begin
      col_pos = '0;
      row_pos = (row_pos == IMG_H - 1) ? '0 : row_pos + 4'd1;
    end else begin
      col_pos = col_pos + 4'd1;
    end
  endfunction

  // APB write: setup, access, then idle
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KERNEL_TOP:    kern[0] = value[KROW_W-1:0];
      REG_KERNEL_MIDDLE: kern[1] = value[KROW_W-1:0];
      REG_KERNEL_BOTTOM: kern[2] = value[KROW_W-1:0];
      REG_BIAS: begin
        bias_r = value[BIAS_W-1:0];
        settings_applied++;
      end
      default: ;
    endcase
  endtask

  task automatic write_bias(input logic signed [BIAS_W-1:0] b);
    write_reg(REG_BIAS, {{(CFG_DW-BIAS_W){b[BIAS_W-1]}}, b});
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic program_random_kernel();
    write_reg(REG_KERNEL_TOP,    {16'h0, pick_coef(), pick_coef(), pick_coef()});
    write_reg(REG_KERNEL_MIDDLE, {16'h0, pick_coef(), pick_coef(), pick_coef()});
    write_reg(REG_KERNEL_BOTTOM, {16'h0, pick_coef(), pick_coef(), pick_coef()});
    write_bias(8'($urandom));
  endtask

  // Send one pixel transaction; the expected result is queued on acceptance.
  // A typed row replaces the modelled value with the one from the table.
  task automatic send_pixel(input c3br_in_t item, input bit typed,
                            input logic signed [CONV_W-1:0] conv_t,
                            input logic [RELU_W-1:0] relu_t);
    bit        produced;
    c3br_out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    convolve_pixel(item, produced, res);
    if (produced) begin
      if (typed) begin
        res.conv_value = conv_t;
        res.relu_value = relu_t;
      end
      conv_results_q.push_back(res);
    end
    pixels_sent++;
  endtask

  // Hold the sender off until every expected result is back, then let the
  // pipeline empty of windows that never yield anything
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (conv_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result channel: random stall and check against the oldest expectation
  always @(posedge clk) begin : result_check
    c3br_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (conv_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, got conv %0d at (%0d,%0d)",
                 $time, out_data.conv_value, out_data.out_row, out_data.out_col);
      end else begin
        want = conv_results_q.pop_front();
        report_field("conv_value", want.conv_value, out_data.conv_value);
        report_field("relu_value", want.relu_value, out_data.relu_value);
        report_field("out_row",    want.out_row,    out_data.out_row);
        report_field("out_col",    want.out_col,    out_data.out_col);
        report_field("frame_last", want.frame_last, out_data.frame_last);
      end
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Stimulus
  initial begin : stimulus
    burst_t                  row;
    c3br_in_t                item;
    logic signed [PIX_W-1:0] pix;
    reset_conv_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bursts
    tx_idle_pct = 17;
    rx_idle_pct = 71;
    for (int b = 0; b < NUM_BURSTS; b++) begin
      row = BURSTS[b];
      if (row.set_cfg) begin
        settle_idle();
        write_reg(REG_KERNEL_TOP,    {16'h0, row.krow});
        write_reg(REG_KERNEL_MIDDLE, {16'h0, row.krow});
        write_reg(REG_KERNEL_BOTTOM, {16'h0, row.krow});
        write_bias(row.bias);
      end
      pix = row.pix0;
      for (int i = 0; i < row.count; i++) begin
        item.pixel       = pix;
        item.frame_start = (i == 0);
        send_pixel(item, row.typed, row.conv_typed, row.relu_typed);
        pix = pix + row.pix_step;
      end
    end

    // Random frames: mostly well-formed, with the odd frame start mid-frame
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 17; rx_idle_pct = 71; end
        1: begin tx_idle_pct = 71; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int set = 0; set < 2; set++) begin
        settle_idle();
        program_random_kernel();
        for (int i = 0; i < PIX_PER_SET; i++) begin
          if (col_pos == 0 && row_pos == 0)
            item.frame_start = ($urandom_range(3) != 0);
          else
            item.frame_start = ($urandom_range(99) == 0);
          if ($urandom_range(9) == 0)
            item.pixel = $urandom_range(1) ? 8'sh7F : 8'sh80;
          else
            item.pixel = 8'($urandom);
          send_pixel(item, 1'b0, '0, '0);
        end
      end
    end

    settle_idle();
    $display("Sent %0d pixels over %0d directed bursts and three idling mixes;",
             pixels_sent, NUM_BURSTS);
    $display("checked %0d results under %0d kernel/bias settings, %0d mismatches.",
             results_seen, settings_applied, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding", conv_results_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/c3br_pkg.sv
hw/rtl/c3br_front.sv
hw/rtl/c3br_queue.sv
hw/rtl/c3br_back.sv
hw/rtl/conv3x3_bias_relu_unit.sv
test/conv3x3_bias_relu_unit_tb.sv
